FILE: hw/rtl/psf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_pkg: shared constants and types for the prime sieve filter chain
// Widths, table size, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package psf_pkg;

    localparam int VALUE_W    = 31;
    localparam int MAX_PRIMES = 64;
    localparam int IDX_W      = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int CNT_W      = $clog2(MAX_PRIMES + 1);
    localparam int BIT_W      = $clog2(VALUE_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_START,
        S_DIV,
        S_TEST,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_cand;
        logic start_div;
        logic step_div;
        logic next_idx;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic div_done;
        logic divides;
        logic last;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/psf_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_rem: bit-serial remainder unit
// Restoring remainder of dividend by divisor, one dividend bit per cycle in which i_step is high.
// ----------------------------------------------------------------------------
module psf_rem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_step,
    input  logic [psf_pkg::VALUE_W-1:0]  i_dividend,
    input  logic [psf_pkg::VALUE_W-1:0]  i_divisor,
    output logic                         o_last,
    output logic [psf_pkg::VALUE_W-1:0]  o_rem
);

    logic [psf_pkg::VALUE_W-1:0] r_div;
    logic [psf_pkg::VALUE_W-1:0] r_shift;
    logic [psf_pkg::VALUE_W-1:0] r_rem;
    logic [psf_pkg::VALUE_W-1:0] n_rem;
    logic [psf_pkg::BIT_W-1:0]   r_bit;
    logic [psf_pkg::VALUE_W:0]   trial;

    // bring down the next dividend bit and subtract where it fits
    always_comb begin
        trial = {r_rem, r_shift[psf_pkg::VALUE_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = psf_pkg::VALUE_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[psf_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= psf_pkg::BIT_W'(psf_pkg::VALUE_W - 1);
        end else if (i_step) begin
            r_bit <= r_bit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div   <= i_divisor;
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (i_step) begin
            r_shift <= {r_shift[psf_pkg::VALUE_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_last = (r_bit == '0);
    assign o_rem  = r_rem;

endmodule

FILE: hw/rtl/psf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_dp: sieve datapath
// Candidate register, prime table memory, remainder unit and result register.
// ----------------------------------------------------------------------------
module psf_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psf_pkg::t_cmd                i_cmd,
    output psf_pkg::t_sts                o_sts,
    input  logic [psf_pkg::VALUE_W-1:0]  i_candidate,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [psf_pkg::VALUE_W-1:0]  o_prime,
    output logic                         o_overflow
);

    logic [psf_pkg::VALUE_W-1:0] mem [psf_pkg::MAX_PRIMES];
    logic [psf_pkg::VALUE_W-1:0] r_cand;
    logic [psf_pkg::VALUE_W-1:0] r_rd_data;
    logic [psf_pkg::IDX_W-1:0]   r_idx;
    logic [psf_pkg::CNT_W-1:0]   r_count;
    logic                        r_out_valid;
    logic [psf_pkg::VALUE_W-1:0] r_prime;
    logic                        r_overflow;
    logic                        full;
    logic                        rem_last;
    logic [psf_pkg::VALUE_W-1:0] rem;

    assign full = (r_count == psf_pkg::CNT_W'(psf_pkg::MAX_PRIMES));

    psf_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_step     (i_cmd.step_div),
        .i_dividend (r_cand),
        .i_divisor  (r_rd_data),
        .o_last     (rem_last),
        .o_rem      (rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cand) begin
            r_cand <= i_candidate;
            r_idx  <= '0;
        end else if (i_cmd.next_idx) begin
            r_idx  <= r_idx + 1'b1;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && !full) begin
            mem[r_count[psf_pkg::IDX_W-1:0]] <= r_cand;
        end
        r_rd_data <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.emit && !full) begin
            r_count <= r_count + 1'b1;
        end
    end

    // result word: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_prime    <= r_cand;
            r_overflow <= full;
        end
    end

    always_comb begin
        o_sts.empty    = (r_count == '0);
        o_sts.div_done = rem_last;
        // zero as a divisor divides only zero
        o_sts.divides  = (r_rd_data == '0) ? (r_cand == '0) : (rem == '0);
        o_sts.last     = ((psf_pkg::CNT_W'(r_idx) + 1'b1) == r_count);
        o_sts.out_free = !r_out_valid || i_res_ready;
    end

    assign o_res_valid = r_out_valid;
    assign o_prime     = r_prime;
    assign o_overflow  = r_overflow;

endmodule

FILE: hw/rtl/psf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_ctrl: sieve controller
// Walks the stored primes one at a time and sequences each remainder test.
// ----------------------------------------------------------------------------
module psf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cand_valid,
    output logic           o_cand_ready,
    input  psf_pkg::t_sts  i_sts,
    output psf_pkg::t_cmd  o_cmd
);

    psf_pkg::t_state r_state;
    psf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cand_ready = 1'b0;
        unique case (r_state)
            psf_pkg::S_IDLE: begin
                o_cand_ready = 1'b1;
                if (i_cand_valid) begin
                    o_cmd.load_cand = 1'b1;
                    n_state = i_sts.empty ? psf_pkg::S_EMIT : psf_pkg::S_FETCH;
                end
            end
            psf_pkg::S_FETCH: begin
                n_state = psf_pkg::S_START;
            end
            psf_pkg::S_START: begin
                o_cmd.start_div = 1'b1;
                n_state = psf_pkg::S_DIV;
            end
            psf_pkg::S_DIV: begin
                o_cmd.step_div = 1'b1;
                if (i_sts.div_done) begin
                    n_state = psf_pkg::S_TEST;
                end
            end
            psf_pkg::S_TEST: begin
                if (i_sts.divides) begin
                    // drop the word
                    n_state = psf_pkg::S_IDLE;
                end else if (i_sts.last) begin
                    n_state = psf_pkg::S_EMIT;
                end else begin
                    o_cmd.next_idx = 1'b1;
                    n_state = psf_pkg::S_FETCH;
                end
            end
            psf_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = psf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = psf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/prime_sieve_filter_chain_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_sieve_filter_chain_top: prime sieve over a stream of candidates
// Drops candidates divisible by a stored prime, stores and emits the rest.
// ----------------------------------------------------------------------------
// One candidate is worked at a time. It is tested against the stored primes in
// table order, each test being a table read, a divider load, 31 steps of the
// bit-serial remainder unit and a compare, and a dropped candidate stops at the
// first divisor. The remainder unit takes one dividend bit per step. Results go
// through an output register, so the next candidate is taken while a result
// still waits. Up to 64 primes are kept; once the table is full a surviving
// candidate is emitted with o_overflow set and not stored.
module prime_sieve_filter_chain_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cand_valid,
    output logic                         o_cand_ready,
    input  logic [psf_pkg::VALUE_W-1:0]  i_candidate,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [psf_pkg::VALUE_W-1:0]  o_prime,
    output logic                         o_overflow
);

    psf_pkg::t_cmd cmd;
    psf_pkg::t_sts sts;

    psf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand_valid (i_cand_valid),
        .o_cand_ready (o_cand_ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    psf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_candidate (i_candidate),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_prime     (o_prime),
        .o_overflow  (o_overflow)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for prime_sieve_filter_chain_top
// Walks a short table of directed candidates, then a long random stream that
// is mostly consecutive integers with noise mixed in. Every accepted word is
// run through a local sieve, and each emitted prime is compared with it or with its typed row.
// ----------------------------------------------------------------------------
module tb;

    localparam int DIRECTED_ROWS  = 24;
    localparam int RANDOM_WORDS   = 1126;
    localparam int TAIL_CYCLES    = 34 * psf_pkg::MAX_PRIMES + 64;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [psf_pkg::VALUE_W-1:0] TOP_VALUE = {psf_pkg::VALUE_W{1'b1}};

    typedef struct packed {
        logic [psf_pkg::VALUE_W-1:0] prime;
        logic                        overflow;
    } t_prime_word;

    // typed rows carry their own expectation; the rest take theirs from the local sieve
    typedef struct packed {
        logic [psf_pkg::VALUE_W-1:0] value;
        logic                        typed;
        logic                        yields;
        logic [psf_pkg::VALUE_W-1:0] prime;
        logic                        overflow;
    } t_stim_row;

    localparam t_stim_row STIM_TABLE [DIRECTED_ROWS] = '{
        // empty table takes zero, then the stored zero drops zero
        '{31'd0,       1'b1, 1'b1, 31'd0,     1'b0},
        '{31'd0,       1'b1, 1'b0, 31'd0,     1'b0},
        // top value passes a lone zero entry, then drops itself
        '{TOP_VALUE,   1'b1, 1'b1, TOP_VALUE, 1'b0},
        '{TOP_VALUE,   1'b1, 1'b0, 31'd0,     1'b0},
        '{31'd2,       1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd0,       1'b1, 1'b0, 31'd0,     1'b0},
        '{31'd3,       1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd4,       1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd5,       1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd6,       1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd7,       1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd8,       1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd9,       1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd10,      1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd11,      1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd12,      1'b0, 1'b0, 31'd0,     1'b0},
        // out of order, wide values
        '{31'h7FFF_FFFE, 1'b0, 1'b0, 31'd0,   1'b0},
        '{31'h4000_0000, 1'b0, 1'b0, 31'd0,   1'b0},
        '{31'h5555_5555, 1'b0, 1'b0, 31'd0,   1'b0},
        '{31'd13,      1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd14,      1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd15,      1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd16,      1'b0, 1'b0, 31'd0,     1'b0},
        '{31'd17,      1'b0, 1'b0, 31'd0,     1'b0}
    };

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_cand_valid = 1'b0;
    logic                        o_cand_ready;
    logic [psf_pkg::VALUE_W-1:0] i_candidate  = '0;
    logic                        o_res_valid;
    logic                        i_res_ready  = 1'b0;
    logic [psf_pkg::VALUE_W-1:0] o_prime;
    logic                        o_overflow;

    // local sieve state
    logic [psf_pkg::VALUE_W-1:0] sieve_table [psf_pkg::MAX_PRIMES];
    int unsigned                 sieve_count = 0;

    t_prime_word        exp_primes [$];
    int                 mismatches  = 0;
    int                 idle_cycles = 0;
    int                 tx_calm     = 0;
    int                 rx_calm     = 0;

    prime_sieve_filter_chain_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand_valid (i_cand_valid),
        .o_cand_ready (o_cand_ready),
        .i_candidate  (i_candidate),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_prime      (o_prime),
        .o_overflow   (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Zero divides only zero; otherwise drop on a zero remainder.
    function automatic bit sieve_word(input logic [psf_pkg::VALUE_W-1:0] cand,
                                      output t_prime_word emitted);
        int unsigned k;
        emitted = '0;
        for (k = 0; k < sieve_count; k++) begin
            if (sieve_table[k] == '0) begin
                if (cand == '0) return 1'b0;
            end else if (cand % sieve_table[k] == '0) begin
                return 1'b0;
            end
        end
        emitted.prime = cand;
        if (sieve_count < psf_pkg::MAX_PRIMES) begin
            sieve_table[sieve_count] = cand;
            sieve_count++;
            emitted.overflow = 1'b0;
        end else begin
            emitted.overflow = 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatches < REPORT_LIMIT)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    task automatic feed_word(input t_stim_row row);
        int          gap;
        bit          yields;
        t_prime_word emitted;
        if (tx_calm > 0) begin
            tx_calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 31) == 0) tx_calm = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            i_cand_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cand_valid <= 1'b1;
        i_candidate  <= row.value;
        @(posedge i_clk);
        while (!o_cand_ready) @(posedge i_clk);
        // word taken at this edge: advance the sieve and log what must come out
        yields = sieve_word(row.value, emitted);
        if (row.typed) begin
            if (row.yields) exp_primes.push_back(t_prime_word'{row.prime, row.overflow});
        end else if (yields) begin
            exp_primes.push_back(emitted);
        end
    endtask

    task automatic drain_results();
        int          gap;
        t_prime_word want;
        forever begin
            if (rx_calm > 0) begin
                rx_calm--;
                gap = 0;
            end else begin
                gap = $urandom_range(0, 16);
                if ($urandom_range(0, 31) == 0) rx_calm = $urandom_range(8, 40);
            end
            if (gap > 0) begin
                i_res_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_res_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_res_valid) @(posedge i_clk);
            if (exp_primes.size() == 0) begin
                flag_mismatch("unexpected word, prime", 32'd0, 32'(o_prime));
            end else begin
                want = exp_primes.pop_front();
                if (o_prime !== want.prime)
                    flag_mismatch("prime", 32'(want.prime), 32'(o_prime));
                if (o_overflow !== want.overflow)
                    flag_mismatch("overflow", 32'(want.overflow), 32'(o_overflow));
            end
        end
    endtask

    // Count cycles with no word moving on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cand_valid && o_cand_ready) || (o_res_valid && i_res_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int                          n;
        int                          pick;
        int                          seq_share;
        int unsigned                 next_seq;
        logic [psf_pkg::VALUE_W-1:0] value;

        next_seq = 18;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_results();
        join_none

        for (n = 0; n < DIRECTED_ROWS; n++)
            feed_word(STIM_TABLE[n]);

        for (n = 0; n < RANDOM_WORDS; n++) begin
            // hold the sender until every pending prime has drained
            if (n % 300 == 150) begin
                i_cand_valid <= 1'b0;
                @(posedge i_clk);
                while (exp_primes.size() != 0) @(posedge i_clk);
            end
            seq_share = (sieve_count < psf_pkg::MAX_PRIMES) ? 85 : 55;
            pick = $urandom_range(0, 99);
            if (pick < seq_share) begin
                value = psf_pkg::VALUE_W'(next_seq);
                next_seq++;
            end else begin
                case ($urandom_range(0, 3))
                    0: value = psf_pkg::VALUE_W'($urandom());
                    1: value = psf_pkg::VALUE_W'($urandom_range(0, 400));
                    2: value = TOP_VALUE - psf_pkg::VALUE_W'($urandom_range(0, 1000));
                    default: value = sieve_table[$urandom_range(0, sieve_count - 1)]
                                     * psf_pkg::VALUE_W'($urandom_range(1, 3));
                endcase
            end
            // a stored one would drop every later word, so keep one out of the table
            if (value == psf_pkg::VALUE_W'(1) && sieve_count < psf_pkg::MAX_PRIMES)
                value = '0;
            feed_word(t_stim_row'{value, 1'b0, 1'b0, {psf_pkg::VALUE_W{1'b0}}, 1'b0});
        end

        // one passes a full table and comes back flagged, unstored
        if (sieve_count == psf_pkg::MAX_PRIMES)
            feed_word(t_stim_row'{psf_pkg::VALUE_W'(1), 1'b0, 1'b0,
                                  {psf_pkg::VALUE_W{1'b0}}, 1'b0});

        i_cand_valid <= 1'b0;
        while (exp_primes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
